// File: rtl/core/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg: shared types and constants of the 3x3 RGB box blur
// Channel layout, configuration register indexes, command codes, size
// limits and the divide-by-nine helper.
// ----------------------------------------------------------------------------
package bb3_pkg;

  // Size limits and register widths
  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned MIN_DIM       = 3;
  localparam int unsigned FW_W          = 11;
  localparam int unsigned FH_W          = 12;
  localparam int unsigned CFG_DATA_W    = 12;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned PIX_W         = 32;
  localparam int unsigned CH_W          = 8;
  localparam int unsigned SUM_W         = 12;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  // Input commands
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

  // x/9 == (x*3641) >> 15 for every x up to 9*255 = 2295
  localparam int unsigned DIV9_MUL   = 3641;
  localparam int unsigned DIV9_SHIFT = 15;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

  // One window column: index 0 top, 1 middle, 2 bottom
  typedef rgb_t [2:0] win_col_t;

  typedef struct packed {
    logic [SUM_W-1:0] r;
    logic [SUM_W-1:0] g;
    logic [SUM_W-1:0] b;
  } rgb_sum_t;

  // Per-word control from the sequencer to the window datapath
  typedef struct packed {
    logic emit;     // word produces a result
    logic col0_en;  // left window column is inside the frame
    logic col2_en;  // right window column is inside the frame
    logic top_en;   // top window row is inside the frame
    logic bot_en;   // bottom window row is inside the frame
    logic eof;      // result is the last of the frame
    logic pix_en;   // word carries a real pixel
  } seq_ctl_t;

  function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] s);
    logic [2*SUM_W-1:0] p;
    p = (2*SUM_W)'(s) * (2*SUM_W)'(DIV9_MUL);
    return p[DIV9_SHIFT +: CH_W];
  endfunction

endpackage

// File: rtl/core/bb3_ram.sv
// ----------------------------------------------------------------------------
// bb3_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered and holds
// while no read is issued. A read of the address being written returns
// the old contents.
// ----------------------------------------------------------------------------
module bb3_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/bb3_seq.sv
// ----------------------------------------------------------------------------
// bb3_seq: column/row sequencer of the box blur
// Tracks the raster position of each accepted word, folds the counters
// back into the frame after a size change, and decides per word whether a
// result is due and which window rows and columns lie inside the frame.
// ----------------------------------------------------------------------------
module bb3_seq #(
  parameter int unsigned MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  logic [bb3_pkg::FW_W-1:0]     frame_width,
  input  logic [bb3_pkg::FH_W-1:0]     frame_height,
  input  logic                         command,
  output bb3_pkg::seq_ctl_t            ctl,
  output logic [$clog2(MAX_WIDTH)-1:0] col_addr
);
  import bb3_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned MWW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WXW = (MWW > FW_W) ? MWW : FW_W;
  localparam int unsigned RW  = FH_W + 1;

  logic [CW-1:0]   col_r, col_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic [WXW-1:0]  fw_ext, w_eff, c_inc;
  logic [FH_W-1:0] h_eff;
  logic [RW-1:0]   h_x, hp1, hp2;
  logic [CW-1:0]   c_n;
  logic [RW-1:0]   r_n;
  logic            emit_a, emit_b;

  always_comb begin
    fw_ext = WXW'(frame_width);
    if (fw_ext > WXW'(MAX_WIDTH)) begin
      w_eff = WXW'(MAX_WIDTH);
    end else if (fw_ext < WXW'(MIN_DIM)) begin
      w_eff = WXW'(MIN_DIM);
    end else begin
      w_eff = fw_ext;
    end
    h_eff = (frame_height < FH_W'(MIN_DIM)) ? FH_W'(MIN_DIM) : frame_height;
    h_x   = RW'(h_eff);
    hp1   = h_x + RW'(1);
    hp2   = h_x + RW'(2);

    // fold a stale position back into the frame
    c_n = col_r;
    r_n = row_r;
    if (WXW'(col_r) >= w_eff) begin
      c_n = '0;
      r_n = row_r + RW'(1);
    end
    if (r_n > hp1) begin
      c_n = '0;
      r_n = '0;
    end

    // column 0 finishes the last pixel two rows up; others the one before
    emit_a = (c_n == '0) && (r_n >= RW'(2)) && (r_n < hp2);
    emit_b = (c_n != '0) && (r_n >= RW'(1)) && (r_n < hp1);

    ctl.emit    = emit_a || emit_b;
    ctl.col0_en = emit_a || (c_n >= CW'(2));
    ctl.col2_en = !emit_a;
    ctl.top_en  = emit_a ? (r_n >= RW'(3)) : (r_n >= RW'(2));
    ctl.bot_en  = emit_a ? (r_n < hp1) : (r_n < h_x);
    ctl.eof     = emit_a && (r_n == hp1);
    ctl.pix_en  = (command == CMD_PIXEL) && (r_n < h_x);
    col_addr    = c_n;

    c_inc = WXW'(c_n) + WXW'(1);
    if (ctl.eof) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (c_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = r_n + RW'(1);
    end else begin
      col_nxt = c_inc[CW-1:0];
      row_nxt = r_n;
    end
    if (row_nxt > hp1) begin
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (advance) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  a_eof_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    advance && ctl.eof |=> col_r == '0 && row_r == '0)
    else $error("frame did not restart after end of frame");

  a_col_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    WXW'(col_r) < WXW'(MAX_WIDTH))
    else $error("column counter beyond line store depth");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    !(emit_a && emit_b))
    else $error("two results due for one word");

endmodule

// File: rtl/core/box_blur_3x3_rgb_unit.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_unit: 3x3 box blur over a raster RGBA8888 pixel stream
// Two line stores in one RAM, a 3x3 window, divide by nine, alpha forced
// to opaque.
// ----------------------------------------------------------------------------
// Feed the pixels of a frame in raster order, then frame_width+1 flush
// words; each blurred pixel is the sum of its 3x3 neighborhood (outside
// pixels count as zero) divided by nine, and results trail the input by
// one row plus one pixel, the last one flagged with out_end_of_frame. The
// unit takes one word per clock unless out_stall backs it up: the two
// line stores share one 48-bit RAM entry per column, read when a word is
// taken and written back as it leaves stage 1, bypassed for back-to-back
// words on one column. Stage 2 registers the sums and the output register
// the result; out_stall holds the pipeline only as far back as it is
// full. Write frame_width and frame_height only while the unit is idle.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_unit #(
  parameter int unsigned MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic [bb3_pkg::PIX_W-1:0]     in_pixel,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bb3_pkg::PIX_W-1:0]     out_pixel,
  output logic                          out_end_of_frame
);
  import bb3_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RGB_W = $bits(rgb_t);
  localparam int unsigned ENT_W = 2 * RGB_W;

  // Configuration
  logic [FW_W-1:0] frame_width_r;
  logic [FH_W-1:0] frame_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[FH_W-1:0];
      endcase
    end
  end

  // Stage enables
  logic en_out, en_s2, en_s1, in_acc, s1_move;
  logic s1_v_r, s2_v_r, out_v_r;

  assign en_out   = !out_v_r || !out_stall;
  assign en_s2    = !s2_v_r || en_out;
  assign en_s1    = !s1_v_r || en_s2;
  assign in_stall = !en_s1;
  assign in_acc   = in_valid && en_s1;
  assign s1_move  = s1_v_r && en_s2;

  // Sequencer
  seq_ctl_t      seq_ctl;
  logic [CW-1:0] seq_addr;

  bb3_seq #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (in_acc),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .command      (in_command),
    .ctl          (seq_ctl),
    .col_addr     (seq_addr)
  );

  // Stage 1: line store read in flight
  seq_ctl_t      s1_ctl_r;
  logic [CW-1:0] s1_addr_r;
  rgb_t          s1_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en_s1) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ctl_r  <= seq_ctl;
      s1_addr_r <= seq_addr;
      s1_pix_r  <= seq_ctl.pix_en ? rgb_t'(in_pixel[PIX_W-1 -: RGB_W]) : '0;
    end
  end

  // Line stores: entry holds {upper row, lower row} of one column
  logic             ram_we, ram_re;
  logic [CW-1:0]    ram_waddr, ram_raddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata, ram_q;
  logic             fwd_r;
  logic [ENT_W-1:0] fwd_data_r;
  rgb_t             st_top, st_mid;

  assign ram_re    = in_acc;
  assign ram_raddr = seq_addr;
  assign ram_we    = s1_move;
  assign ram_waddr = s1_addr_r;
  assign ram_q     = fwd_r ? fwd_data_r : ram_rdata;
  assign st_top    = rgb_t'(ram_q[ENT_W-1 -: RGB_W]);
  assign st_mid    = rgb_t'(ram_q[RGB_W-1:0]);
  assign ram_wdata = {st_mid, s1_pix_r};

  bb3_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // bypass a write-back to the column being read in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (ram_re) begin
      fwd_r <= ram_we && (ram_waddr == ram_raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      fwd_data_r <= ram_wdata;
    end
  end

  // Window and neighborhood sums
  win_col_t win_r [3];
  win_col_t nw    [3];
  logic [2:0] col_en, row_en;
  rgb_sum_t   sum;

  always_comb begin
    nw[0]    = win_r[1];
    nw[1]    = win_r[2];
    nw[2][0] = st_top;
    nw[2][1] = st_mid;
    nw[2][2] = s1_pix_r;
    col_en   = {s1_ctl_r.col2_en, 1'b1, s1_ctl_r.col0_en};
    row_en   = {s1_ctl_r.bot_en, 1'b1, s1_ctl_r.top_en};
    sum      = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (col_en[i] && row_en[j]) begin
          sum.r = sum.r + SUM_W'(nw[i][j].r);
          sum.g = sum.g + SUM_W'(nw[i][j].g);
          sum.b = sum.b + SUM_W'(nw[i][j].b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_move) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i] <= nw[i];
      end
    end
  end

  // Stage 2: sums
  rgb_sum_t s2_sum_r;
  logic     s2_eof_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en_s2) begin
      s2_v_r <= s1_v_r && s1_ctl_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s2) begin
      s2_sum_r <= sum;
      s2_eof_r <= s1_ctl_r.eof;
    end
  end

  // Output register: divide by nine, repack with opaque alpha
  logic [PIX_W-1:0] out_pixel_r;
  logic             out_eof_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en_out) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_pixel_r <= {div9(s2_sum_r.r), div9(s2_sum_r.g), div9(s2_sum_r.b), ALPHA_OPAQUE};
      out_eof_r   <= s2_eof_r;
    end
  end

  assign out_valid        = out_v_r;
  assign out_pixel        = out_pixel_r;
  assign out_end_of_frame = out_eof_r;

  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r && s2_v_r && out_v_r)
    else $error("input stalled with room in the pipeline");

  a_bypass_taken: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && ram_re && (ram_waddr == ram_raddr) |=> fwd_r)
    else $error("same-column write-back not bypassed");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    en_s2 && !(s1_v_r && s1_ctl_r.emit) |=> !s2_v_r)
    else $error("result staged for a word that produces none");

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the 3x3 RGB box blur unit
// Drives raster frames with flush tails through the pixel channel, mirrors
// the line stores, window and counters in a local predictor, and checks
// every blurred word and end-of-frame flag in order. Sizes include the
// clamped extremes, frames broken off mid-way and a long output hold.
// ----------------------------------------------------------------------------
module testbench;
  import bb3_pkg::*;

  localparam int unsigned MAXW = MAX_WIDTH_DEF;

  localparam logic [PIX_W-1:0] ONES  = 32'hFFFF_FFFF;
  localparam logic [PIX_W-1:0] ZERO  = 32'h0000_0000;
  localparam logic [PIX_W-1:0] BLUR4 = 32'h7171_71FF;  // four full pixels / 9
  localparam logic [PIX_W-1:0] BLUR6 = 32'hAAAA_AAFF;  // six full pixels / 9
  localparam logic [PIX_W-1:0] BLUR9 = 32'hFFFF_FFFF;  // whole window full
  localparam logic [PIX_W-1:0] BLACK = 32'h0000_00FF;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             eof;
  } blur_word_t;

  typedef struct packed {
    logic             cmd;
    logic [PIX_W-1:0] pixel;
    logic             chk;
    logic [PIX_W-1:0] want_pixel;
    logic             want_eof;
  } dir_row_t;

  typedef enum {RX_FREE, RX_SPARSE, RX_PERIODIC, RX_HEAVY} rx_mode_t;

  // Two 3x3 frames: all white (one with alpha cleared), then all black with
  // flush words inside the frame and pixel words past its end.
  localparam dir_row_t DIR_TAB [26] = '{
    '{CMD_PIXEL, ONES,          1'b0, ZERO,  1'b0},
    '{CMD_PIXEL, 32'hFFFF_FF00, 1'b0, ZERO,  1'b0},
    '{CMD_PIXEL, ONES,          1'b0, ZERO,  1'b0},
    '{CMD_PIXEL, ONES,          1'b0, ZERO,  1'b0},
    '{CMD_PIXEL, ONES,          1'b1, BLUR4, 1'b0},
    '{CMD_PIXEL, ONES,          1'b1, BLUR6, 1'b0},
    '{CMD_PIXEL, ONES,          1'b1, BLUR4, 1'b0},
    '{CMD_PIXEL, ONES,          1'b1, BLUR6, 1'b0},
    '{CMD_PIXEL, ONES,          1'b1, BLUR9, 1'b0},
    '{CMD_FLUSH, ONES,          1'b1, BLUR6, 1'b0},
    '{CMD_FLUSH, ONES,          1'b1, BLUR4, 1'b0},
    '{CMD_FLUSH, ONES,          1'b1, BLUR6, 1'b0},
    '{CMD_FLUSH, ONES,          1'b1, BLUR4, 1'b1},
    '{CMD_PIXEL, ZERO,          1'b0, ZERO,  1'b0},
    '{CMD_FLUSH, ONES,          1'b0, ZERO,  1'b0},
    '{CMD_PIXEL, ZERO,          1'b0, ZERO,  1'b0},
    '{CMD_PIXEL, ZERO,          1'b0, ZERO,  1'b0},
    '{CMD_PIXEL, ZERO,          1'b1, BLACK, 1'b0},
    '{CMD_PIXEL, ZERO,          1'b1, BLACK, 1'b0},
    '{CMD_PIXEL, ZERO,          1'b1, BLACK, 1'b0},
    '{CMD_FLUSH, ONES,          1'b1, BLACK, 1'b0},
    '{CMD_PIXEL, ZERO,          1'b1, BLACK, 1'b0},
    '{CMD_PIXEL, ONES,          1'b1, BLACK, 1'b0},
    '{CMD_PIXEL, ONES,          1'b1, BLACK, 1'b0},
    '{CMD_PIXEL, ONES,          1'b1, BLACK, 1'b0},
    '{CMD_PIXEL, ONES,          1'b1, BLACK, 1'b1}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_command = CMD_PIXEL;
  logic [PIX_W-1:0]      in_pixel = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PIX_W-1:0]      out_pixel;
  logic                  out_end_of_frame;

  // Predictor state
  logic [23:0]  up_line [MAXW];
  logic [23:0]  lo_line [MAXW];
  logic [23:0]  win [3][3];  // [column left..right][row top..bottom]
  int unsigned  col_pos;
  int unsigned  row_pos;
  logic [FW_W-1:0] reg_width;
  logic [FH_W-1:0] reg_height;

  blur_word_t   blur_due [$];
  blur_word_t   head;
  int unsigned  words_in = 0;
  int unsigned  pixels_out = 0;
  int unsigned  mismatches = 0;
  int unsigned  size_settings = 0;
  int unsigned  burst_left = 0;
  logic         long_hold = 1'b0;
  rx_mode_t     rx_mode = RX_FREE;
  int unsigned  rx_left = 0;
  int unsigned  rx_run = 0;
  int unsigned  rx_tick = 0;
  logic         rx_want;

  box_blur_3x3_rgb_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_pixel         (in_pixel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel        (out_pixel),
    .out_end_of_frame (out_end_of_frame)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned eff_width(input logic [FW_W-1:0] w);
    if (w > MAXW) return MAXW;
    if (w < MIN_DIM) return MIN_DIM;
    return w;
  endfunction

  function automatic int unsigned eff_height(input logic [FH_W-1:0] h);
    if (h < MIN_DIM) return MIN_DIM;
    return h;
  endfunction

  // Average of window columns first..2; top and bottom rows drop out at
  // the frame edges, the divisor stays nine.
  function automatic logic [PIX_W-1:0] win_avg(input int unsigned first,
                                               input int unsigned crow,
                                               input int unsigned h);
    int unsigned sr, sg, sb;
    sr = 0;
    sg = 0;
    sb = 0;
    for (int unsigned c = first; c < 3; c++) begin
      for (int unsigned r = 0; r < 3; r++) begin
        if ((r != 0 || crow > 0) && (r != 2 || crow + 1 < h)) begin
          sr += win[c][r][23:16];
          sg += win[c][r][15:8];
          sb += win[c][r][7:0];
        end
      end
    end
    return {8'(sr / 9), 8'(sg / 9), 8'(sb / 9), ALPHA_OPAQUE};
  endfunction

  function automatic void blur_clear();
    for (int unsigned i = 0; i < MAXW; i++) begin
      up_line[i] = '0;
      lo_line[i] = '0;
    end
    for (int unsigned c = 0; c < 3; c++)
      for (int unsigned r = 0; r < 3; r++)
        win[c][r] = '0;
    col_pos = 0;
    row_pos = 0;
    reg_width = FRAME_WIDTH_RST;
    reg_height = FRAME_HEIGHT_RST;
  endfunction

  function automatic void next_blur(input logic cmd, input logic [PIX_W-1:0] pix,
                                    output bit got, output blur_word_t res);
    int unsigned w, h, c, r;
    logic [23:0] v, top, mid;
    bit eof;
    got = 0;
    eof = 0;
    res = '0;
    w = eff_width(reg_width);
    h = eff_height(reg_height);
    // wrap counters left past a size change
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos > h + 1) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    r = row_pos;
    v = (cmd == CMD_PIXEL && r < h) ? pix[31:8] : '0;
    top = up_line[c];
    mid = lo_line[c];
    up_line[c] = mid;
    lo_line[c] = v;
    // column 0 closes the last pixel of the row two above
    if (c == 0 && r >= 2 && r - 2 < h) begin
      res.pixel = win_avg(1, r - 2, h);
      eof = (r - 2 == h - 1);
      res.eof = eof;
      got = 1;
    end
    for (int unsigned k = 0; k < 3; k++) begin
      win[0][k] = win[1][k];
      win[1][k] = win[2][k];
    end
    win[2][0] = top;
    win[2][1] = mid;
    win[2][2] = v;
    if (c >= 1 && r >= 1 && r - 1 < h) begin
      res.pixel = win_avg(c >= 2 ? 0 : 1, r - 1, h);
      res.eof = 1'b0;
      got = 1;
    end
    if (eof) begin
      col_pos = 0;
      row_pos = 0;
    end else begin
      col_pos = c + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = r + 1;
      end
      if (row_pos > h + 1) begin
        col_pos = 0;
        row_pos = 0;
      end
    end
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0: return ONES;
      1: return ZERO;
      default: return $urandom();
    endcase
  endfunction

  // Offer one word in a burst; a new burst may start after a random gap.
  task automatic send_word(input logic cmd, input logic [PIX_W-1:0] pix);
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    in_valid = 1'b1;
    in_command = cmd;
    in_pixel = pix;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    words_in++;
  endtask

  task automatic feed(input logic cmd, input logic [PIX_W-1:0] pix);
    blur_word_t res;
    bit got;
    send_word(cmd, pix);
    next_blur(cmd, pix, got, res);
    if (got) blur_due.push_back(res);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_FRAME_WIDTH) reg_width = val[FW_W-1:0];
    else reg_height = val[FH_W-1:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_size(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    size_settings++;
  endtask

  // Drop valid, wait out every pending word, then let the pipe empty.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (blur_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Pixels of a frame (a few flush words inside), then the flush tail with
  // an occasional pixel word past the end; stop_at breaks the frame off.
  task automatic send_frame(input int unsigned ew, input int unsigned eh,
                            input int unsigned stop_at);
    for (int unsigned i = 0; i < ew * eh + ew + 1 && i < stop_at; i++) begin
      if (i < ew * eh)
        feed(($urandom_range(0, 39) == 0) ? CMD_FLUSH : CMD_PIXEL, pick_pixel());
      else
        feed(($urandom_range(0, 7) == 0) ? CMD_PIXEL : CMD_FLUSH, pick_pixel());
    end
  endtask

  // Receiver: switch between stall patterns; outside the long hold a run of
  // stalls is cut short by a forced free cycle.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(32, 300);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_FREE:     rx_want = 1'b0;
      RX_SPARSE:   rx_want = ($urandom_range(0, 3) == 0);
      RX_PERIODIC: rx_want = (rx_tick % 3 == 2);
      default:     rx_want = ($urandom_range(0, 9) < 7);
    endcase
    if (rx_run >= 3) rx_want = 1'b0;
    rx_run = rx_want ? rx_run + 1 : 0;
    out_stall = rx_want | long_hold;
  end

  // Hold the output long enough that the unit backs up into its input.
  initial begin
    wait (words_in >= 800);
    @(posedge clk);
    long_hold = 1'b1;
    repeat (400) @(posedge clk);
    long_hold = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (blur_due.size() == 0) begin
        $error("out_pixel: no word expected, got %08h", out_pixel);
        mismatches++;
      end else begin
        head = blur_due.pop_front();
        pixels_out++;
        if (out_pixel !== head.pixel) begin
          $error("out_pixel: expected %08h, got %08h", head.pixel, out_pixel);
          mismatches++;
        end
        if (out_end_of_frame !== head.eof) begin
          $error("out_end_of_frame: expected %0b, got %0b", head.eof, out_end_of_frame);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #4_800_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    blur_word_t res;
    bit got;
    int unsigned goal, ew, eh, nfr;
    logic [CFG_DATA_W-1:0] w_val, h_val;
    blur_clear();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed frames at sizes below the minimum, clamped to 3 x 3
    set_size(12'd2, 12'd0);
    for (int i = 0; i < 26; i++) begin
      send_word(DIR_TAB[i].cmd, DIR_TAB[i].pixel);
      next_blur(DIR_TAB[i].cmd, DIR_TAB[i].pixel, got, res);
      if (DIR_TAB[i].chk) begin
        res.pixel = DIR_TAB[i].want_pixel;
        res.eof = DIR_TAB[i].want_eof;
        got = 1;
      end
      if (got) blur_due.push_back(res);
    end
    settle();

    // Widest frame; fills every line store entry
    set_size(12'hFFF, 12'd3);
    send_frame(MAXW, 3, MAXW * 4 + 1);
    settle();

    // Tallest frame, broken off after fifty rows
    set_size(12'h000, 12'hFFF);
    send_frame(MIN_DIM, 4095, 150);
    settle();

    goal = words_in + 1100;
    while (words_in < goal) begin
      case ($urandom_range(0, 9))
        0: w_val = $urandom_range(0, 2);
        1: w_val = $urandom_range(13, 40);
        2: w_val = 12'h800 | $urandom_range(3, 12);  // bit 11 falls off
        default: w_val = $urandom_range(3, 12);
      endcase
      h_val = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      set_size(w_val, h_val);
      ew = eff_width(w_val[FW_W-1:0]);
      eh = eff_height(h_val);
      nfr = $urandom_range(1, 3);
      repeat (nfr) begin
        case ($urandom_range(0, 9))
          0: repeat ($urandom_range(1, 20)) feed(1'($urandom_range(0, 1)), pick_pixel());
          1: send_frame(ew, eh, $urandom_range(1, ew * eh));
          default: send_frame(ew, eh, ew * eh + ew + 1);
        endcase
      end
      settle();
    end

    $display("Covered %0d input words and %0d blurred pixels over %0d size settings.",
             words_in, pixels_out, size_settings);
    $display("Sizes ran from clamped 3 x 3 up to 1024 x 3 and 3 x 4095, with a long output hold.");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
